@@ hw/rtl/amsco_pkg.sv @@
// ============================================================================
// AMSCO transposition package
// Shared types, register indexes and reset constants of the AMSCO block.
// ============================================================================
package amsco_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int KEYLEN_W = 4;
    localparam int CFG_DW   = 36;
    localparam int CFG_IW   = 2;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MODE       = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_KEY_DIGITS = 2'd2
    } t_cfg_idx;

    localparam logic                MODE_ENC   = 1'b0;
    localparam logic                MODE_DEC   = 1'b1;
    localparam logic [KEYLEN_W-1:0] KEYLEN_RST = 4'd9;
    localparam logic [CFG_DW-1:0]   KEY_RST    = 36'd40926266145;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_in;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_out;
        logic              overflow;
    } t_out_req;

    typedef struct packed {
        logic rd;
        logic done;
    } t_unit_stat;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PERMUTE,
        ST_DRAIN,
        ST_EMIT
    } t_top_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SIZE,
        SQ_OFFSET,
        SQ_PLACE
    } t_seq_state;

endpackage

@@ hw/rtl/amsco_ram.sv @@
// ============================================================================
// AMSCO byte memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module amsco_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/amsco_seq.sv @@
// ============================================================================
// AMSCO column sequencer
// Sizes the columns cell by cell, builds per-column output pointers from the
// key digits, then walks the message byte by byte giving each byte's place.
// ============================================================================
module amsco_seq #(
    parameter int MAX_LEN = 64,
    parameter int MAX_KEY = 9
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0]              i_count,
    input  logic [((MAX_KEY > 1) ? $clog2(MAX_KEY) : 1)-1:0] i_lm1,
    input  logic [amsco_pkg::CFG_DW-1:0]              i_key,
    output amsco_pkg::t_unit_stat                     o_stat,
    output logic [$clog2(MAX_LEN)-1:0]                o_walk_addr,
    output logic [$clog2(MAX_LEN)-1:0]                o_dst_addr
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int DW = amsco_pkg::DIGIT_W;

    amsco_pkg::t_seq_state r_state, n_state;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_two, n_two;
    logic          r_hi, n_hi;
    logic [KW-1:0] r_col, n_col;
    logic [KW-1:0] r_d, n_d;
    logic [CW-1:0] r_len [MAX_KEY];
    logic [CW-1:0] n_len [MAX_KEY];
    logic [CW-1:0] r_ptr [MAX_KEY];
    logic [CW-1:0] n_ptr [MAX_KEY];

    logic [DW-1:0] w_digit [MAX_KEY];
    logic          w_rem_two;
    logic [CW-1:0] w_clen;
    logic [CW-1:0] w_pos_nx;
    logic [KW-1:0] w_col_nx;
    logic          w_cell_end;

    always_comb begin
        for (int c = 0; c < MAX_KEY; c++) begin
            w_digit[c] = i_key[DW*c +: DW];
        end
    end

    assign w_rem_two  = (r_pos + CW'(1)) < i_count;
    assign w_clen     = (r_two && w_rem_two) ? CW'(2) : CW'(1);
    assign w_pos_nx   = r_pos + w_clen;
    assign w_col_nx   = (r_col == i_lm1) ? '0 : r_col + KW'(1);
    assign w_cell_end = !r_two || r_hi || !w_rem_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amsco_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_two <= n_two;
        r_hi  <= n_hi;
        r_col <= n_col;
        r_d   <= n_d;
        r_len <= n_len;
        r_ptr <= n_ptr;
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_two   = r_two;
        n_hi    = r_hi;
        n_col   = r_col;
        n_d     = r_d;
        n_len   = r_len;
        n_ptr   = r_ptr;
        o_stat  = '0;
        case (r_state)
            amsco_pkg::SQ_IDLE: begin
                if (i_start) begin
                    n_state = amsco_pkg::SQ_SIZE;
                    n_pos   = '0;
                    n_two   = 1'b0;
                    n_hi    = 1'b0;
                    n_col   = '0;
                    for (int c = 0; c < MAX_KEY; c++) begin
                        n_len[c] = '0;
                        n_ptr[c] = '0;
                    end
                end
            end
            amsco_pkg::SQ_SIZE: begin
                n_len[r_col] = r_len[r_col] + w_clen;
                n_pos        = w_pos_nx;
                n_col        = w_col_nx;
                n_two        = !r_two;
                if (w_pos_nx == i_count) begin
                    n_state = amsco_pkg::SQ_OFFSET;
                    n_d     = '0;
                end
            end
            amsco_pkg::SQ_OFFSET: begin
                for (int c = 0; c < MAX_KEY; c++) begin
                    if (w_digit[r_d] < w_digit[c]) begin
                        n_ptr[c] = r_ptr[c] + r_len[r_d];
                    end
                end
                if (r_d == KW'(MAX_KEY - 1)) begin
                    n_state = amsco_pkg::SQ_PLACE;
                    n_pos   = '0;
                    n_two   = 1'b0;
                    n_hi    = 1'b0;
                    n_col   = '0;
                end else begin
                    n_d = r_d + KW'(1);
                end
            end
            amsco_pkg::SQ_PLACE: begin
                o_stat.rd = 1'b1;
                for (int c = 0; c < MAX_KEY; c++) begin
                    if (w_digit[c] == w_digit[r_col]) begin
                        n_ptr[c] = r_ptr[c] + CW'(1);
                    end
                end
                n_pos = r_pos + CW'(1);
                if (w_cell_end) begin
                    n_col = w_col_nx;
                    n_two = !r_two;
                    n_hi  = 1'b0;
                end else begin
                    n_hi = 1'b1;
                end
                if (!w_rem_two) begin
                    n_state     = amsco_pkg::SQ_IDLE;
                    o_stat.done = 1'b1;
                end
            end
            default: begin
                n_state = amsco_pkg::SQ_IDLE;
            end
        endcase
    end

    assign o_walk_addr = r_pos[AW-1:0];
    assign o_dst_addr  = r_ptr[r_col][AW-1:0];

`ifndef SYNTH
    a_dst_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.rd |-> (r_ptr[r_col] < i_count))
        else $error("placement target beyond message length");
`endif

endmodule

@@ hw/rtl/amsco_emit.sv @@
// ============================================================================
// AMSCO result emitter
// Reads the permuted message in order and hands it out through an output
// register with a skid stage, one byte per cycle when not stalled.
// ============================================================================
module amsco_emit #(
    parameter int MAX_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0]        i_count,
    input  logic                                i_ovf,
    output amsco_pkg::t_unit_stat               o_stat,
    output logic [$clog2(MAX_LEN)-1:0]          o_rd_addr,
    input  logic [amsco_pkg::BYTE_W-1:0]        i_rd_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output amsco_pkg::t_out_req                 o_data
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    logic                r_active, n_active;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_pend, n_pend;
    logic                r_pend_last, n_pend_last;
    logic                r_out_valid, n_out_valid;
    logic                r_skid_valid, n_skid_valid;
    amsco_pkg::t_out_req r_out, n_out;
    amsco_pkg::t_out_req r_skid, n_skid;

    logic                w_take;
    logic [1:0]          w_occ;
    logic                w_issue;
    amsco_pkg::t_out_req w_rd_req;

    assign w_take  = r_out_valid && !i_stall;
    assign w_occ   = 2'(r_out_valid) + 2'(r_skid_valid) + 2'(r_pend) - 2'(w_take);
    assign w_issue = r_active && (r_addr < i_count) && (w_occ < 2'd2);

    assign w_rd_req.out_byte = i_rd_data;
    assign w_rd_req.last_out = r_pend_last;
    assign w_rd_req.overflow = i_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
        r_skid      <= n_skid;
    end

    always_comb begin
        n_active     = r_active;
        n_addr       = r_addr;
        n_pend       = w_issue;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        o_stat.rd    = w_issue;
        o_stat.done  = w_take && r_out.last_out;

        if (i_start) begin
            n_active = 1'b1;
            n_addr   = '0;
        end else if (o_stat.done) begin
            n_active = 1'b0;
        end
        if (w_issue) begin
            n_addr      = r_addr + CW'(1);
            n_pend_last = (r_addr + CW'(1)) == i_count;
        end

        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = w_rd_req;
                n_skid_valid = r_pend;
            end else begin
                n_out       = w_rd_req;
                n_out_valid = r_pend;
            end
        end else if (r_pend) begin
            n_skid       = w_rd_req;
            n_skid_valid = 1'b1;
        end
    end

    assign o_rd_addr = r_addr[AW-1:0];
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a request ahead of the output register");
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_out_valid, r_skid_valid, r_pend}) <= 2)
        else $error("more requests in flight than output storage");
`endif

endmodule

@@ hw/rtl/amsco_transposition_cipher.sv @@
// ============================================================================
// AMSCO transposition cipher
// Buffers a message, permutes it by AMSCO transposition and emits the result.
// ============================================================================
// Input channel: one message byte per request, last_in on the final byte.
// While loading, a byte is taken every cycle; bytes past MAX_LEN are dropped
// and every result byte of that message then carries overflow.
// After the final byte the input stalls while the block works on the message
// of n bytes in two memories (message and result, registered read):
//   column sizing   : one cell per step, about 2n/3 cells
//   column pointers : one step per key digit, over all MAX_KEY digits
//   placement       : one memory read and write per byte
//   then a drain state lets the last write land before the result is read back.
// Results leave at one per cycle while not stalled, last_out on the final
// byte. The receiver may stall at any time: the output register and a skid
// stage hold the pending bytes and reads of the result memory pause. Input
// resumes the cycle after the last result is taken.
// Mode and key are sampled with the final byte; write them while idle.
// Reset returns to loading with an empty buffer and the default key.
// ============================================================================
module amsco_transposition_cipher #(
    parameter int MAX_LEN = 64,
    parameter int MAX_KEY = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [amsco_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  logic [amsco_pkg::CFG_DW-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  amsco_pkg::t_in_req                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output amsco_pkg::t_out_req               o_out_data
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int BW = amsco_pkg::BYTE_W;
    localparam int LW = amsco_pkg::KEYLEN_W;

    amsco_pkg::t_top_state r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_ovf, n_ovf;
    logic                          r_mode, n_mode;
    logic [KW-1:0]                 r_lm1, n_lm1;
    logic [amsco_pkg::CFG_DW-1:0]  r_key, n_key;
    logic                          r_cfg_mode;
    logic [LW-1:0]                 r_cfg_klen;
    logic [amsco_pkg::CFG_DW-1:0]  r_cfg_key;
    logic                          r_wr_en;
    logic [AW-1:0]                 r_wr_addr;

    logic                  w_accept;
    logic                  w_room;
    logic                  w_msg_we;
    logic                  w_seq_start;
    logic                  w_emit_start;
    logic [KW-1:0]         w_klm1;
    amsco_pkg::t_unit_stat w_seq_stat;
    amsco_pkg::t_unit_stat w_emit_stat;
    logic [AW-1:0]         w_walk_addr;
    logic [AW-1:0]         w_dst_addr;
    logic [AW-1:0]         w_msg_raddr;
    logic [BW-1:0]         w_msg_rdata;
    logic [AW-1:0]         w_res_raddr;
    logic [BW-1:0]         w_res_rdata;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_room   = r_count < CW'(MAX_LEN);
    assign w_msg_we = w_accept && w_room;

    always_comb begin
        if (r_cfg_klen == '0) begin
            w_klm1 = '0;
        end else if (r_cfg_klen > LW'(MAX_KEY)) begin
            w_klm1 = KW'(MAX_KEY - 1);
        end else begin
            w_klm1 = KW'(r_cfg_klen - LW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode <= amsco_pkg::MODE_ENC;
            r_cfg_klen <= amsco_pkg::KEYLEN_RST;
            r_cfg_key  <= amsco_pkg::KEY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                amsco_pkg::CFG_MODE:       r_cfg_mode <= i_cfg_data[0];
                amsco_pkg::CFG_KEY_LENGTH: r_cfg_klen <= i_cfg_data[LW-1:0];
                amsco_pkg::CFG_KEY_DIGITS: r_cfg_key  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amsco_pkg::ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_wr_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_wr_en <= w_seq_stat.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_lm1     <= n_lm1;
        r_key     <= n_key;
        r_wr_addr <= (r_mode == amsco_pkg::MODE_ENC) ? w_dst_addr : w_walk_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_mode       = r_mode;
        n_lm1        = r_lm1;
        n_key        = r_key;
        o_in_stall   = 1'b1;
        w_seq_start  = 1'b0;
        w_emit_start = 1'b0;
        case (r_state)
            amsco_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_in) begin
                        n_state     = amsco_pkg::ST_PERMUTE;
                        n_mode      = r_cfg_mode;
                        n_lm1       = w_klm1;
                        n_key       = r_cfg_key;
                        w_seq_start = 1'b1;
                    end
                end
            end
            amsco_pkg::ST_PERMUTE: begin
                if (w_seq_stat.done) begin
                    n_state = amsco_pkg::ST_DRAIN;
                end
            end
            amsco_pkg::ST_DRAIN: begin
                w_emit_start = 1'b1;
                n_state      = amsco_pkg::ST_EMIT;
            end
            amsco_pkg::ST_EMIT: begin
                if (w_emit_stat.done) begin
                    n_state = amsco_pkg::ST_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = amsco_pkg::ST_LOAD;
            end
        endcase
    end

    assign w_msg_raddr = (r_mode == amsco_pkg::MODE_ENC) ? w_walk_addr : w_dst_addr;

    amsco_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (BW)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (w_msg_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_data.text_byte),
        .i_re    (w_seq_stat.rd),
        .i_raddr (w_msg_raddr),
        .o_rdata (w_msg_rdata)
    );

    amsco_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (BW)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (r_wr_en),
        .i_waddr (r_wr_addr),
        .i_wdata (w_msg_rdata),
        .i_re    (w_emit_stat.rd),
        .i_raddr (w_res_raddr),
        .o_rdata (w_res_rdata)
    );

    amsco_seq #(
        .MAX_LEN (MAX_LEN),
        .MAX_KEY (MAX_KEY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_seq_start),
        .i_count     (r_count),
        .i_lm1       (r_lm1),
        .i_key       (r_key),
        .o_stat      (w_seq_stat),
        .o_walk_addr (w_walk_addr),
        .o_dst_addr  (w_dst_addr)
    );

    amsco_emit #(
        .MAX_LEN (MAX_LEN)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_emit_start),
        .i_count   (r_count),
        .i_ovf     (r_ovf),
        .o_stat    (w_emit_stat),
        .o_rd_addr (w_res_raddr),
        .i_rd_data (w_res_rdata),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

`ifndef SYNTH
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.last_in) |=> o_in_stall)
        else $error("input not stalled after the final byte");
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == amsco_pkg::ST_EMIT))
        else $error("result request outside the emit phase");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("byte count beyond buffer capacity");
`endif

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// AMSCO transposition cipher testbench
// Streams messages into the cipher under changing modes and keys, predicts
// every permuted byte with an in-bench AMSCO transposer, and compares each
// result byte with the oldest prediction while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_CAP = 64;
    localparam int KEY_CAP = 9;
    localparam int RANDOM_REQUESTS = 280;
    localparam logic [amsco_pkg::CFG_IW-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } t_stall_style;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [amsco_pkg::CFG_IW-1:0]   i_cfg_idx = amsco_pkg::CFG_MODE;
    logic [amsco_pkg::CFG_DW-1:0]   i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    amsco_pkg::t_in_req             i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    amsco_pkg::t_out_req            o_out_data;

    amsco_transposition_cipher #(
        .MAX_LEN(MSG_CAP),
        .MAX_KEY(KEY_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state
    logic                           cipher_mode = amsco_pkg::MODE_ENC;
    logic [amsco_pkg::KEYLEN_W-1:0] column_cfg = amsco_pkg::KEYLEN_RST;
    logic [amsco_pkg::CFG_DW-1:0]   key_cfg = amsco_pkg::KEY_RST;
    logic [amsco_pkg::BYTE_W-1:0]   msg_bytes [MSG_CAP];
    int unsigned                    msg_fill = 0;
    logic                           msg_dropped = 1'b0;
    amsco_pkg::t_out_req            pending_cipher_bytes[$];

    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned burst_left = 0;

    t_stall_style stall_style = STALL_NONE;
    int unsigned  style_left = 0;
    int unsigned  hold_left = 0;
    logic         hold_val = 1'b0;

    function automatic logic [amsco_pkg::CFG_DW-1:0] random36();
        return amsco_pkg::CFG_DW'({$urandom(), $urandom()});
    endfunction

    function automatic void transpose_message(input int unsigned n);
        int unsigned cols, pos, size, col, cells, len, k;
        int unsigned cell_start [MSG_CAP];
        int unsigned cell_len [MSG_CAP];
        int unsigned cell_col [MSG_CAP];
        int unsigned src [MSG_CAP];
        logic [amsco_pkg::BYTE_W-1:0] permuted [MSG_CAP];
        amsco_pkg::t_out_req r;
        cols = column_cfg;
        if (cols < 1) cols = 1;
        if (cols > KEY_CAP) cols = KEY_CAP;
        pos = 0;
        size = 1;
        col = 0;
        cells = 0;
        while (pos < n) begin
            len = (size > n - pos) ? n - pos : size;
            cell_start[cells] = pos;
            cell_len[cells] = len;
            cell_col[cells] = col;
            cells++;
            pos += len;
            col = (col + 1) % cols;
            size = 3 - size;
        end
        // gather cells by ascending digit, row order inside each digit
        k = 0;
        for (int v = 0; v < 16; v++) begin
            for (int j = 0; j < cells; j++) begin
                if (key_cfg[4*cell_col[j] +: amsco_pkg::DIGIT_W] == v) begin
                    for (int b = 0; b < cell_len[j]; b++) begin
                        src[k] = cell_start[j] + b;
                        k++;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            if (cipher_mode == amsco_pkg::MODE_ENC) permuted[i] = msg_bytes[src[i]];
            else permuted[src[i]] = msg_bytes[i];
        end
        for (int i = 0; i < n; i++) begin
            r.out_byte = permuted[i];
            r.last_out = (i == n - 1);
            r.overflow = msg_dropped;
            pending_cipher_bytes.push_back(r);
        end
    endfunction

    function automatic void note_request(input amsco_pkg::t_in_req req);
        if (msg_fill < MSG_CAP) begin
            msg_bytes[msg_fill] = req.text_byte;
            msg_fill++;
        end else begin
            msg_dropped = 1'b1;
        end
        if (req.last_in) begin
            transpose_message(msg_fill);
            msg_fill = 0;
            msg_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Each task starts and ends just after a rising edge.
    task automatic send_byte(input logic [amsco_pkg::BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        amsco_pkg::t_in_req req;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req.text_byte = b;
        req.last_in = last;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        note_request(req);
        requests_sent++;
        burst_left--;
    endtask

    task automatic send_random_message(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            send_byte(amsco_pkg::BYTE_W'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_cipher_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [amsco_pkg::CFG_IW-1:0] idx,
                             input logic [amsco_pkg::CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            amsco_pkg::CFG_MODE:       cipher_mode = data[0];
            amsco_pkg::CFG_KEY_LENGTH: column_cfg = data[amsco_pkg::KEYLEN_W-1:0];
            amsco_pkg::CFG_KEY_DIGITS: key_cfg = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic mode, input logic [amsco_pkg::KEYLEN_W-1:0] cols,
                             input logic [amsco_pkg::CFG_DW-1:0] digits);
        logic [amsco_pkg::CFG_DW-1:0] noise;
        noise = random36();
        wait_idle();
        write_reg(amsco_pkg::CFG_MODE, {noise[amsco_pkg::CFG_DW-1:1], mode});
        write_reg(amsco_pkg::CFG_KEY_LENGTH,
                  {noise[amsco_pkg::CFG_DW-1:amsco_pkg::KEYLEN_W], cols});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE, random36());
        write_reg(amsco_pkg::CFG_KEY_DIGITS, digits);
    endtask

    function automatic logic [amsco_pkg::CFG_DW-1:0] make_key(
        input logic [amsco_pkg::KEYLEN_W-1:0] cols);
        logic [amsco_pkg::CFG_DW-1:0] digits;
        int unsigned perm [KEY_CAP];
        int unsigned n, j, t;
        digits = random36();
        if ($urandom_range(0, 3) == 0) return digits;
        n = (cols < 1) ? 1 : (cols > KEY_CAP) ? KEY_CAP : cols;
        for (int i = 0; i < KEY_CAP; i++) perm[i] = i + 1;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < n; i++) begin
            digits[4*i +: amsco_pkg::DIGIT_W] = amsco_pkg::DIGIT_W'(perm[i]);
        end
        return digits;
    endfunction

    task automatic test_default_key();
        logic [amsco_pkg::BYTE_W-1:0] pattern [6];
        pattern = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
        for (int i = 0; i < 6; i++) send_byte(pattern[i], i == 5);
    endtask

    task automatic test_key_length_limits();
        configure(amsco_pkg::MODE_DEC, 4'd0, make_key(4'd0));
        send_random_message(1);
        configure(amsco_pkg::MODE_ENC, 4'd1, make_key(4'd1));
        send_random_message(2);
        configure(amsco_pkg::MODE_DEC, 4'd15, make_key(4'd15));
        send_random_message(5);
    endtask

    task automatic test_repeated_digits();
        configure(amsco_pkg::MODE_ENC, 4'd9, '0);
        send_random_message(4);
        configure(amsco_pkg::MODE_DEC, 4'd9, '1);
        send_random_message(4);
        configure(amsco_pkg::MODE_ENC, 4'd5, 36'h000022313);
        send_random_message(3);
    endtask

    task automatic test_buffer_full();
        configure(amsco_pkg::MODE_ENC, 4'd9, make_key(4'd9));
        send_random_message(MSG_CAP);
        configure(amsco_pkg::MODE_DEC, 4'd7, make_key(4'd7));
        send_random_message(MSG_CAP + 1);
        configure(amsco_pkg::MODE_ENC, 4'd4, make_key(4'd4));
        send_random_message(MSG_CAP + 6);
    endtask

    task automatic test_random_messages();
        logic [amsco_pkg::KEYLEN_W-1:0] cols;
        int unsigned n, pick;
        int unsigned target;
        target = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target) begin
            if ($urandom_range(0, 1) == 0) begin
                cols = ($urandom_range(0, 7) == 0) ?
                       amsco_pkg::KEYLEN_W'($urandom_range(0, 15)) :
                       amsco_pkg::KEYLEN_W'($urandom_range(1, 9));
                configure(1'($urandom_range(0, 1)), cols, make_key(cols));
            end
            pick = $urandom_range(0, 19);
            if (pick < 17) n = $urandom_range(1, 16);
            else if (pick < 19) n = $urandom_range(17, MSG_CAP);
            else n = $urandom_range(MSG_CAP + 1, MSG_CAP + 16);
            send_random_message(n);
        end
    endtask

    always @(posedge i_clk) begin
        amsco_pkg::t_out_req want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_cipher_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %h", o_out_data.out_byte));
            end else begin
                want = pending_cipher_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              o_out_data.out_byte, want.out_byte));
                if (o_out_data.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %b, want %b",
                                              o_out_data.last_out, want.last_out));
                if (o_out_data.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              o_out_data.overflow, want.overflow));
            end
        end
        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            style_left = $urandom_range(30, 200);
        end
        style_left--;
        case (stall_style)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    hold_val = !hold_val;
                    hold_left = hold_val ? $urandom_range(5, 20) : $urandom_range(1, 8);
                end
                hold_left--;
                i_out_stall <= hold_val;
            end
        endcase
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_key();
        test_key_length_limits();
        test_repeated_digits();
        test_buffer_full();
        test_random_messages();
        wait_idle();
        repeat (2 * MSG_CAP) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d result bytes outstanding", pending_cipher_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/amsco_pkg.sv
hw/rtl/amsco_ram.sv
hw/rtl/amsco_seq.sv
hw/rtl/amsco_emit.sv
hw/rtl/amsco_transposition_cipher.sv
dv/tb.sv
